// ----- hw/rtl/accumulated_pixel_tonemap_assert.svh -----
// Assertion macros shared by the tonemap RTL.
`ifndef ACCUMULATED_PIXEL_TONEMAP_ASSERT_SVH
`define ACCUMULATED_PIXEL_TONEMAP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define APT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition that must hold on every clock edge outside reset.
`define APT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/apt_pkg.sv -----
`timescale 1ns / 1ps
package apt_pkg;
    localparam int SUM_W  = 40;
    localparam int CNT_W  = 24;
    localparam int GAIN_W = 16;
    localparam int HALF_W = 20;
    localparam int PROD_W = 56;
    localparam int DEN_W  = 57;
    localparam int T_W    = 16;
    localparam int SQ_W   = 32;
    localparam int BYTE_W = 8;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd17920;
    localparam logic [DEN_W-1:0]  ONE_UQ24   = 57'd16777216;
    localparam logic [GAIN_W-1:0] SCALE_SQ   = 16'd65025;
endpackage

// ----- hw/rtl/apt_pix_in_if.sv -----
`timescale 1ns / 1ps
interface apt_pix_in_if;
    import apt_pkg::*;
    logic              valid;
    logic              ready;
    logic [SUM_W-1:0]  sum_red;
    logic [SUM_W-1:0]  sum_green;
    logic [SUM_W-1:0]  sum_blue;
    logic [CNT_W-1:0]  sample_count;

    modport source (output valid, sum_red, sum_green, sum_blue, sample_count, input ready);
    modport sink (input valid, sum_red, sum_green, sum_blue, sample_count, output ready);
endinterface

// ----- hw/rtl/apt_pix_out_if.sv -----
`timescale 1ns / 1ps
interface apt_pix_out_if;
    import apt_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] red_out;

    modport source (output valid, blue_out, green_out, red_out, input ready);
    modport sink (input valid, blue_out, green_out, red_out, output ready);
endinterface

// ----- hw/rtl/accumulated_pixel_tonemap.sv -----
// Throughput: one pixel per cycle; all stages advance together and hold on a stall.
// Stages: 40 divider bits, 2 multiply, 16 curve-divider bits, 1 multiply, 16 root bits.
// Reset: async active low clears valid bits; gain_reg returns to 70.0.
`timescale 1ns / 1ps
`include "accumulated_pixel_tonemap_assert.svh"
module accumulated_pixel_tonemap
    import apt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GAIN_W-1:0] cfg_wdata,
    apt_pix_in_if.sink        pix_in,
    apt_pix_out_if.source     pix_out
);
    logic [GAIN_W-1:0] gain_reg;
    logic              en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            gain_reg <= cfg_wdata;
        end
    end

    assign en           = !pix_out.valid || pix_out.ready;
    assign pix_in.ready = en;

    logic [SUM_W-1:0]  sums   [0:2];
    logic              mv     [0:2];
    logic [SUM_W-1:0]  means  [0:2];
    logic              tv     [0:2];
    logic [T_W-1:0]    ts     [0:2];
    logic              bv     [0:2];
    logic [BYTE_W-1:0] bytes_o [0:2];
    logic              bytes_ok;

    // channel 0 blue, 1 green, 2 red
    assign sums[0] = pix_in.sum_blue;
    assign sums[1] = pix_in.sum_green;
    assign sums[2] = pix_in.sum_red;

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_chan
            apt_mean_div u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (pix_in.valid),
                .sum       (sums[c]),
                .count     (pix_in.sample_count),
                .out_valid (mv[c]),
                .mean      (means[c])
            );

            apt_curve u_curve (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (mv[c]),
                .mean      (means[c]),
                .gain      (gain_reg),
                .out_valid (tv[c]),
                .t         (ts[c])
            );

            apt_sqrt u_sqrt (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (tv[c]),
                .t         (ts[c]),
                .out_valid (bv[c]),
                .byte_out  (bytes_o[c])
            );
        end
    endgenerate

    assign pix_out.valid     = bv[0];
    assign pix_out.blue_out  = bytes_o[0];
    assign pix_out.green_out = bytes_o[1];
    assign pix_out.red_out   = bytes_o[2];

    assign bytes_ok = (pix_out.blue_out != 8'hFF) && (pix_out.green_out != 8'hFF)
                      && (pix_out.red_out != 8'hFF);

    `APT_ASSERT_IMP(a_no_full_byte, pix_out.valid, bytes_ok)
    `APT_ASSERT_IMP(a_stall_blocks_in, pix_out.valid && !pix_out.ready, !pix_in.ready)
    `APT_ASSERT_IMP(a_lanes_aligned, 1'b1, (bv[0] == bv[1]) && (bv[1] == bv[2]))
    `APT_ASSERT_IMP(a_empty_accepts, !pix_out.valid, pix_in.ready)
endmodule

// ----- hw/rtl/apt_mean_div.sv -----
`timescale 1ns / 1ps
module apt_mean_div
    import apt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [SUM_W-1:0] sum,
    input  logic [CNT_W-1:0] count,
    output logic             out_valid,
    output logic [SUM_W-1:0] mean
);
    // restoring divide, one quotient bit per stage
    logic             cur_v   [0:SUM_W-1];
    logic [SUM_W-1:0] cur_nq  [0:SUM_W-1];
    logic [CNT_W-1:0] cur_rem [0:SUM_W-1];
    logic [CNT_W-1:0] cur_cnt [0:SUM_W-1];
    logic             v_reg   [0:SUM_W-1];
    logic [SUM_W-1:0] nq_reg  [0:SUM_W-1];
    logic [CNT_W-1:0] rem_reg [0:SUM_W-1];
    logic [CNT_W-1:0] cnt_reg [0:SUM_W-1];

    genvar k;
    generate
        for (k = 0; k < SUM_W; k++)
        begin : g_stage
            logic [CNT_W:0]   r2;
            logic             ge;
            logic [CNT_W:0]   diff;
            logic [CNT_W-1:0] rem_next;
            logic [SUM_W-1:0] nq_next;

            if (k == 0)
            begin : g_first
                assign cur_v[k]   = in_valid;
                assign cur_nq[k]  = sum;
                assign cur_rem[k] = '0;
                assign cur_cnt[k] = count;
            end
            else
            begin : g_rest
                assign cur_v[k]   = v_reg[k-1];
                assign cur_nq[k]  = nq_reg[k-1];
                assign cur_rem[k] = rem_reg[k-1];
                assign cur_cnt[k] = cnt_reg[k-1];
            end

            assign r2       = {cur_rem[k], cur_nq[k][SUM_W-1]};
            assign diff     = r2 - {1'b0, cur_cnt[k]};
            assign ge       = r2 >= {1'b0, cur_cnt[k]};
            assign rem_next = ge ? diff[CNT_W-1:0] : r2[CNT_W-1:0];
            assign nq_next  = {cur_nq[k][SUM_W-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= cur_v[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[k]  <= nq_next;
                    rem_reg[k] <= rem_next;
                    cnt_reg[k] <= cur_cnt[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SUM_W-1];
    assign mean      = (cnt_reg[SUM_W-1] == '0) ? '0 : nq_reg[SUM_W-1];
endmodule

// ----- hw/rtl/apt_curve.sv -----
`timescale 1ns / 1ps
module apt_curve
    import apt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  mean,
    input  logic [GAIN_W-1:0] gain,
    output logic              out_valid,
    output logic [T_W-1:0]    t
);
    localparam int PART_W = HALF_W + GAIN_W;

    // split 40x16 product
    logic              va_reg;
    logic [PART_W-1:0] lo_reg;
    logic [PART_W-1:0] hi_reg;
    logic              vb_reg;
    logic [PROD_W-1:0] p_reg;
    logic [DEN_W-1:0]  d_reg;
    logic [PROD_W-1:0] p_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    assign p_next = {hi_reg, {HALF_W{1'b0}}} + {{(PROD_W-PART_W){1'b0}}, lo_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= mean[HALF_W-1:0] * gain;
            hi_reg <= mean[SUM_W-1:HALF_W] * gain;
            p_reg  <= p_next;
            d_reg  <= {1'b0, p_next} + ONE_UQ24;
        end
    end

    // t = p * 2^16 / (p + 1.0), one bit per stage
    logic             cur_v [0:T_W-1];
    logic [DEN_W-1:0] cur_r [0:T_W-1];
    logic [DEN_W-1:0] cur_d [0:T_W-1];
    logic [T_W-1:0]   cur_q [0:T_W-1];
    logic             v_reg [0:T_W-1];
    logic [DEN_W-1:0] r_reg [0:T_W-1];
    logic [DEN_W-1:0] d_st_reg [0:T_W-1];
    logic [T_W-1:0]   q_reg [0:T_W-1];

    genvar k;
    generate
        for (k = 0; k < T_W; k++)
        begin : g_stage
            logic [DEN_W:0] r2;
            logic [DEN_W:0] diff;
            logic           ge;

            if (k == 0)
            begin : g_first
                assign cur_v[k] = vb_reg;
                assign cur_r[k] = {1'b0, p_reg};
                assign cur_d[k] = d_reg;
                assign cur_q[k] = '0;
            end
            else
            begin : g_rest
                assign cur_v[k] = v_reg[k-1];
                assign cur_r[k] = r_reg[k-1];
                assign cur_d[k] = d_st_reg[k-1];
                assign cur_q[k] = q_reg[k-1];
            end

            assign r2   = {cur_r[k], 1'b0};
            assign diff = r2 - {1'b0, cur_d[k]};
            assign ge   = r2 >= {1'b0, cur_d[k]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= cur_v[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]    <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
                    d_st_reg[k] <= cur_d[k];
                    q_reg[k]    <= {cur_q[k][T_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[T_W-1];
    assign t         = q_reg[T_W-1];
endmodule

// ----- hw/rtl/apt_sqrt.sv -----
`timescale 1ns / 1ps
module apt_sqrt
    import apt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [T_W-1:0]    t,
    output logic              out_valid,
    output logic [BYTE_W-1:0] byte_out
);
    localparam int ROOT_W = SQ_W / 2;

    logic            vm_reg;
    logic [SQ_W-1:0] x_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_in_reg <= t * SCALE_SQ;
        end
    end

    // bit-by-bit integer square root, one root bit per stage
    logic            cur_v   [0:ROOT_W-1];
    logic [SQ_W-1:0] cur_x   [0:ROOT_W-1];
    logic [SQ_W-1:0] cur_res [0:ROOT_W-1];
    logic            v_reg   [0:ROOT_W-1];
    logic [SQ_W-1:0] x_reg   [0:ROOT_W-1];
    logic [SQ_W-1:0] res_reg [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            logic [SQ_W-1:0] trial;
            logic            ge;

            if (k == 0)
            begin : g_first
                assign cur_v[k]   = vm_reg;
                assign cur_x[k]   = x_in_reg;
                assign cur_res[k] = '0;
            end
            else
            begin : g_rest
                assign cur_v[k]   = v_reg[k-1];
                assign cur_x[k]   = x_reg[k-1];
                assign cur_res[k] = res_reg[k-1];
            end

            assign trial = cur_res[k] + BIT;
            assign ge    = cur_x[k] >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= cur_v[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]   <= ge ? (cur_x[k] - trial) : cur_x[k];
                    res_reg[k] <= ge ? ((cur_res[k] >> 1) + BIT) : (cur_res[k] >> 1);
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[ROOT_W-1];
    assign byte_out  = res_reg[ROOT_W-1][ROOT_W-1:ROOT_W-BYTE_W];
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import apt_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] sample_count;
    } pixel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] blue_out;
        logic [BYTE_W-1:0] green_out;
        logic [BYTE_W-1:0] red_out;
    } bgr_t;

    localparam int LATENCY   = 75;
    localparam int WDOG_MAX  = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [GAIN_W-1:0] cfg_wdata = '0;

    apt_pix_in_if  pix_in ();
    apt_pix_out_if pix_out ();

    accumulated_pixel_tonemap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix_in    (pix_in.sink),
        .pix_out   (pix_out.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pixel_t pending_pixels[$];
    bgr_t   expected_bytes[$];
    logic [GAIN_W-1:0] gain_model = GAIN_RESET;
    int errors = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    bit in_fire = 1'b0;
    bit out_fire = 1'b0;

    initial
    begin
        pix_in.valid = 1'b0;
        pix_in.sum_red = '0;
        pix_in.sum_green = '0;
        pix_in.sum_blue = '0;
        pix_in.sample_count = '0;
        pix_out.ready = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] tonemap_channel(logic [SUM_W-1:0] sum,
                                                         logic [CNT_W-1:0] cnt,
                                                         logic [GAIN_W-1:0] gain);
        logic [63:0] mean, p, d, r, t, x, res, bit_v;
        if (cnt == 0)
            return '0;
        mean = 64'(sum) / 64'(cnt);
        p = mean * 64'(gain);
        d = p + 64'd16777216;
        r = p;
        t = 0;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            t = t << 1;
            if (r >= d)
            begin
                r = r - d;
                t[0] = 1'b1;
            end
        end
        x = 64'd65025 * t;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (x >= res + bit_v)
            begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
                res = res >> 1;
            bit_v = bit_v >> 2;
        end
        return res[15:8];
    endfunction

    function automatic logic [SUM_W-1:0] rand_sum();
        logic [SUM_W-1:0] v;
        v = SUM_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 39);
            1: v = v & 40'hFFFFFFFFFF;
            default: v = v >> $urandom_range(16, 34);
        endcase
        return v;
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.sum_red = rand_sum();
        px.sum_green = rand_sum();
        px.sum_blue = rand_sum();
        px.sample_count = CNT_W'($urandom);
        case ($urandom_range(0, 4))
            0: px.sample_count = px.sample_count >> $urandom_range(0, 23);
            1: px.sample_count = CNT_W'($urandom_range(0, 64));
            2: px.sample_count = CNT_W'($urandom_range(0, 4096));
            default: ;
        endcase
        return px;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                void'(pending_pixels.pop_front());
                send_wait = $urandom_range(0, 8);
            end
            if (!pix_in.valid || in_fire)
            begin
                if (pending_pixels.size() != 0 && send_wait == 0)
                begin
                    pix_in.valid <= 1'b1;
                    pix_in.sum_red <= pending_pixels[0].sum_red;
                    pix_in.sum_green <= pending_pixels[0].sum_green;
                    pix_in.sum_blue <= pending_pixels[0].sum_blue;
                    pix_in.sample_count <= pending_pixels[0].sample_count;
                end
                else
                begin
                    pix_in.valid <= 1'b0;
                    if (send_wait > 0)
                        send_wait--;
                end
            end
            if (out_fire)
                recv_wait = $urandom_range(0, 8);
            if (recv_wait > 0)
            begin
                recv_wait--;
                pix_out.ready <= 1'b0;
            end
            else
                pix_out.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        bgr_t exp_b;
        pixel_t px;
        if (rst_n)
        begin
            in_fire = pix_in.valid && pix_in.ready;
            out_fire = pix_out.valid && pix_out.ready;
            if (in_fire)
            begin
                px = pending_pixels[0];
                exp_b.blue_out = tonemap_channel(px.sum_blue, px.sample_count, gain_model);
                exp_b.green_out = tonemap_channel(px.sum_green, px.sample_count, gain_model);
                exp_b.red_out = tonemap_channel(px.sum_red, px.sample_count, gain_model);
                expected_bytes.push_back(exp_b);
            end
            if (out_fire)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected output beat");
                    errors++;
                end
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    if (pix_out.blue_out !== exp_b.blue_out)
                    begin
                        $error("blue_out exp %0d got %0d", exp_b.blue_out, pix_out.blue_out);
                        errors++;
                    end
                    if (pix_out.green_out !== exp_b.green_out)
                    begin
                        $error("green_out exp %0d got %0d", exp_b.green_out, pix_out.green_out);
                        errors++;
                    end
                    if (pix_out.red_out !== exp_b.red_out)
                    begin
                        $error("red_out exp %0d got %0d", exp_b.red_out, pix_out.red_out);
                        errors++;
                    end
                end
            end
            if (in_fire || out_fire
                || (pending_pixels.size() == 0 && expected_bytes.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
                timed_out = 1'b1;
        end
    end

    initial
    begin
        wait (timed_out);
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic write_gain(logic [GAIN_W-1:0] g);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        gain_model = g;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_pixels.size() == 0 && expected_bytes.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic push_pixel(logic [SUM_W-1:0] r, logic [SUM_W-1:0] g,
                              logic [SUM_W-1:0] b, logic [CNT_W-1:0] c);
        pixel_t px;
        px.sum_red = r;
        px.sum_green = g;
        px.sum_blue = b;
        px.sample_count = c;
        pending_pixels.push_back(px);
    endtask

    logic [GAIN_W-1:0] gain_list[6] = '{GAIN_RESET, 16'hFFFF, 16'h0000, 16'h0100, 16'h0001,
                                         16'h8000};

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: reset gain first
        push_pixel('0, '0, '0, '0);
        push_pixel('1, '1, '1, '0);
        push_pixel('1, '1, '1, '1);
        push_pixel('1, '0, 40'h10000, 24'd1);
        push_pixel(40'h10000, 40'h8000, 40'h1, 24'd1);
        push_pixel('1, '1, '1, '1 - 24'd0);
        push_pixel(40'h123456789A, 40'h0F0F0F0F0F, 40'hF0F0F0F0F0, 24'd3);
        push_pixel(40'h5555555555, 40'hAAAAAAAAAA, 40'h0, 24'hAAAAAA);
        push_pixel(40'hAAAAAAAAAA, 40'h5555555555, 40'h1, 24'h555555);
        drain();
        write_gain(16'hFFFF);
        push_pixel('1, '1, '1, 24'd1);
        push_pixel(40'h10000, 40'h1, 40'h100, 24'd1);
        push_pixel(40'h5555555555, 40'hAAAAAAAAAA, 40'h0, 24'd0);
        drain();
        write_gain(16'h0000);
        push_pixel('1, '1, '1, 24'd1);
        push_pixel(40'h10000, 40'h10000, 40'h10000, 24'd1);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_gain(ph == 5 ? GAIN_W'($urandom) : gain_list[ph]);
            for (int k = 0; k < 75; k++)
                pending_pixels.push_back(rand_pixel());
            // pause sender until everything has come back
            drain();
        end
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
